// ===== rtl/core/pfba_pkg.sv =====
// Shared constants, types and helpers for the page frame bitmap allocator.
// No dependencies.
package pfba_pkg;

  localparam int TOTAL_FRAMES    = 8192;
  localparam int BITMAP_WORDS    = 1024;
  localparam int RESERVED_FRAMES = 1024;
  localparam int WORD_BITS       = 8;
  localparam logic [WORD_BITS-1:0] FULL_WORD = 8'hFF;

  localparam int FRAME_W = 13;
  localparam int CNT_W   = 14;
  localparam int WORD_AW = $clog2(BITMAP_WORDS);
  localparam int BIT_W   = $clog2(WORD_BITS);

  localparam int BITMAP_CAP  = BITMAP_WORDS * WORD_BITS;
  localparam int FRAME_LIMIT = (TOTAL_FRAMES < BITMAP_CAP) ? TOTAL_FRAMES : BITMAP_CAP;
  localparam int RESV_COUNT  = (RESERVED_FRAMES < TOTAL_FRAMES) ? RESERVED_FRAMES : TOTAL_FRAMES;
  localparam int RESV_MARK   = (RESV_COUNT < FRAME_LIMIT) ? RESV_COUNT : FRAME_LIMIT;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_W-1:0]     bit_idx;
    logic [WORD_BITS-1:0] set_word;
  } scan_res_t;

  // Reset contents of one bitmap word: bits of reserved frames are set.
  function automatic logic [WORD_BITS-1:0] resv_word(input logic [WORD_AW-1:0] idx);
    logic [WORD_BITS-1:0] w;
    w = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if ((int'(idx) * WORD_BITS + b) < RESV_MARK) begin
        w[b] = 1'b1;
      end
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/pfba_if.sv =====
// Request and response channel interfaces of the page frame allocator.
// Depends on pfba_pkg.
interface pfba_req_if;
  import pfba_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [FRAME_W-1:0] frame_number;
  modport source (output valid, output op, output frame_number, input ready);
  modport sink (input valid, input op, input frame_number, output ready);
endinterface

interface pfba_rsp_if;
  import pfba_pkg::*;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] granted_frame;
  logic               ok;
  logic [CNT_W-1:0]   used_count;
  logic [CNT_W-1:0]   free_count;
  modport source (output valid, output granted_frame, output ok, output used_count,
                  output free_count, input ready);
  modport sink (input valid, input granted_frame, input ok, input used_count,
                input free_count, output ready);
endinterface

// ===== rtl/core/page_frame_bitmap_allocator_unit.sv =====
// First-fit page frame allocator over a used/free bitmap of 8-bit words.
// Depends on pfba_pkg, pfba_if, pfba_bitmap_store and pfba_word_scan.
//
// in_ch carries requests (op, frame_number); out_ch returns one result item per
// request: granted_frame, ok and the used/free counters after the request.
// One request is processed at a time; in_ch.ready is high only while idle.
// Allocate reads bitmap words from word 0 upward, one read issued per cycle
// through the single read port, and stops at the first word with a clear bit.
// An allocate examines at most BITMAP_WORDS (1024) words. A free below the
// frame limit takes a read and a write-back of the frame's word; a free out
// of range goes straight to the result. The next request is taken in the
// cycle after the result is loaded.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// block holds that result and stays busy until out_ch.ready.
// After reset the bitmap is initialized in a pass over all BITMAP_WORDS (1024)
// words, one word per cycle, reserved frames marked used; no request is
// accepted during that pass. Counters reset to the reserved count and the
// rest, and both saturate at 0 and at the frame total.
module page_frame_bitmap_allocator_unit (
  input  logic            clk,
  input  logic            rst_n,
  pfba_req_if.sink        in_ch,
  pfba_rsp_if.source      out_ch
);
  import pfba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_AW-1:0]   clr_ptr_r, clr_ptr_nxt;
  logic [WORD_AW:0]     rd_ptr_r, rd_ptr_nxt;
  logic                 pend_r, pend_nxt;
  logic [WORD_AW-1:0]   chk_idx_r, chk_idx_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [CNT_W-1:0]     free_r, free_nxt;
  logic [FRAME_W-1:0]   res_frame_r, res_frame_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [CNT_W-1:0]     out_used_r, out_used_nxt;
  logic [CNT_W-1:0]     out_free_r, out_free_nxt;

  mem_req_t             mreq;
  logic [WORD_BITS-1:0] rd_data;
  scan_res_t            scan;
  logic [FRAME_W-1:0]   cand_frame;
  logic                 in_acc;
  logic                 load_out;

  pfba_bitmap_store u_store (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  pfba_word_scan u_scan (
    .word (rd_data),
    .res  (scan)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign in_acc               = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.granted_frame = out_frame_r;
  assign out_ch.ok            = out_ok_r;
  assign out_ch.used_count    = out_used_r;
  assign out_ch.free_count    = out_free_r;

  assign cand_frame = FRAME_W'({chk_idx_r, scan.bit_idx});
  assign load_out   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    clr_ptr_nxt   = clr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    pend_nxt      = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    frame_nxt     = frame_r;
    used_nxt      = used_r;
    free_nxt      = free_r;
    res_frame_nxt = res_frame_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_frame_nxt = out_frame_r;
    out_ok_nxt    = out_ok_r;
    out_used_nxt  = out_used_r;
    out_free_nxt  = out_free_r;
    mreq          = '0;

    case (state_r)
      S_CLEAR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = clr_ptr_r;
        mreq.wr_data = resv_word(clr_ptr_r);
        clr_ptr_nxt  = clr_ptr_r + 1'b1;
        if (clr_ptr_r == WORD_AW'(BITMAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          frame_nxt     = in_ch.frame_number;
          rd_ptr_nxt    = '0;
          res_frame_nxt = '0;
          res_ok_nxt    = 1'b0;
          if (in_ch.op == OP_FREE) begin
            state_nxt = (int'(in_ch.frame_number) < FRAME_LIMIT) ? S_FREE_RD : S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mreq.rd_en   = !rd_ptr_r[WORD_AW];
        mreq.rd_addr = rd_ptr_r[WORD_AW-1:0];
        if (mreq.rd_en) begin
          rd_ptr_nxt  = rd_ptr_r + 1'b1;
          chk_idx_nxt = rd_ptr_r[WORD_AW-1:0];
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          if (scan.found) begin
            pend_nxt  = 1'b0;
            state_nxt = S_DONE;
            if (int'(cand_frame) < FRAME_LIMIT) begin
              mreq.wr_en    = 1'b1;
              mreq.wr_addr  = chk_idx_r;
              mreq.wr_data  = scan.set_word;
              res_frame_nxt = cand_frame;
              res_ok_nxt    = 1'b1;
              if (int'(used_r) < TOTAL_FRAMES) used_nxt = used_r + 1'b1;
              if (free_r != '0) free_nxt = free_r - 1'b1;
            end
          end else if (chk_idx_r == WORD_AW'(BITMAP_WORDS - 1)) begin
            pend_nxt  = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_FREE_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = frame_r[FRAME_W-1:BIT_W];
        state_nxt    = S_FREE_WR;
      end
      S_FREE_WR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = frame_r[FRAME_W-1:BIT_W];
        mreq.wr_data = rd_data;
        mreq.wr_data[frame_r[BIT_W-1:0]] = 1'b0;
        res_ok_nxt   = 1'b1;
        if (used_r != '0) used_nxt = used_r - 1'b1;
        if (int'(free_r) < TOTAL_FRAMES) free_nxt = free_r + 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_frame_nxt = res_frame_r;
          out_ok_nxt    = res_ok_r;
          out_used_nxt  = used_r;
          out_free_nxt  = free_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ptr_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= CNT_W'(RESV_COUNT);
      free_r      <= CNT_W'(TOTAL_FRAMES - RESV_COUNT);
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      free_r      <= free_nxt;
    end
    rd_ptr_r    <= rd_ptr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    frame_r     <= frame_nxt;
    res_frame_r <= res_frame_nxt;
    res_ok_r    <= res_ok_nxt;
    out_frame_r <= out_frame_nxt;
    out_ok_r    <= out_ok_nxt;
    out_used_r  <= out_used_nxt;
    out_free_r  <= out_free_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("request taken while busy");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(used_r) <= TOTAL_FRAMES && int'(free_r) <= TOTAL_FRAMES)
    else $error("frame counter out of range");

  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.wr_en |-> state_r != S_IDLE && state_r != S_DONE)
    else $error("bitmap written outside an operation");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && in_ch.ready)
    else $error("result not presented after completion");

endmodule

// ===== rtl/core/pfba_bitmap_store.sv =====
// Frame bitmap storage: one write port, one read port with registered data.
// Depends on pfba_pkg.
module pfba_bitmap_store (
  input  logic                               clk,
  input  pfba_pkg::mem_req_t                 req,
  output logic [pfba_pkg::WORD_BITS-1:0]     rd_data
);
  import pfba_pkg::*;

  logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/core/pfba_word_scan.sv =====
// Lowest-clear-bit finder for one bitmap word, shared by every scan step.
// Depends on pfba_pkg.
module pfba_word_scan (
  input  logic [pfba_pkg::WORD_BITS-1:0] word,
  output pfba_pkg::scan_res_t            res
);
  import pfba_pkg::*;

  always_comb begin
    res.found    = 1'b0;
    res.bit_idx  = '0;
    res.set_word = word;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        res.found   = 1'b1;
        res.bit_idx = BIT_W'(b);
      end
    end
    res.set_word[res.bit_idx] = 1'b1;
  end

endmodule

// ===== dv/frame_alloc_checker.sv =====
// Checker for the page frame allocator: watches the request and result channels,
// keeps its own copy of the frame bitmap and counters, and compares every result.
// Depends on pfba_pkg and pfba_if.
module frame_alloc_checker (
  input  logic clk,
  input  logic rst_n,
  pfba_req_if  req_mon,
  pfba_rsp_if  rsp_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfba_pkg::*;

  typedef struct packed {
    logic [FRAME_W-1:0] granted_frame;
    logic               ok;
    logic [CNT_W-1:0]   used_count;
    logic [CNT_W-1:0]   free_count;
  } frame_result_t;

  logic [WORD_BITS-1:0] frame_map [BITMAP_WORDS];
  int unsigned          frames_in_use;
  int unsigned          frames_free;
  frame_result_t        expected_results [$];

  function automatic void reset_frame_map();
    for (int w = 0; w < BITMAP_WORDS; w++) begin
      frame_map[w] = '0;
    end
    for (int f = 0; f < RESV_MARK; f++) begin
      frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
    end
    frames_in_use = RESV_COUNT;
    frames_free   = TOTAL_FRAMES - RESV_COUNT;
  endfunction

  // First fit: skip full words, take the lowest clear bit below the frame limit.
  function automatic bit claim_lowest_frame(output int unsigned frame);
    frame = 0;
    for (int w = 0; w < BITMAP_WORDS; w++) begin
      if (frame_map[w] != FULL_WORD) begin
        for (int b = 0; b < WORD_BITS; b++) begin
          if (w * WORD_BITS + b >= FRAME_LIMIT) begin
            return 1'b0;
          end
          if (!frame_map[w][b]) begin
            frame_map[w][b] = 1'b1;
            frame = w * WORD_BITS + b;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic frame_result_t predict_result(op_t op, logic [FRAME_W-1:0] frame);
    frame_result_t r;
    int unsigned   got;
    r = '0;
    if (op == OP_ALLOC) begin
      if (claim_lowest_frame(got)) begin
        if (frames_in_use < TOTAL_FRAMES) frames_in_use++;
        if (frames_free > 0) frames_free--;
        r.granted_frame = got[FRAME_W-1:0];
        r.ok            = 1'b1;
      end
    end else if (int'(frame) < FRAME_LIMIT) begin
      // double free leaves the bit clear but still moves the counters
      frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
      if (frames_in_use > 0) frames_in_use--;
      if (frames_free < TOTAL_FRAMES) frames_free++;
      r.ok = 1'b1;
    end
    r.used_count = frames_in_use[CNT_W-1:0];
    r.free_count = frames_free[CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      reset_frame_map();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        expected_results.push_back(predict_result(op_t'(req_mon.op), req_mon.frame_number));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("granted_frame", want.granted_frame, rsp_mon.granted_frame);
          check_field("ok", want.ok, rsp_mon.ok);
          check_field("used_count", want.used_count, rsp_mon.used_count);
          check_field("free_count", want.free_count, rsp_mon.free_count);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the page frame allocator testbench: clock, reset, request stimulus,
// receiver stalls, watchdog and verdict. Depends on pfba_pkg, pfba_if,
// frame_alloc_checker and page_frame_bitmap_allocator_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pfba_pkg::*;

  localparam int RANDOM_ITEMS   = 555;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1100;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   fail_count;
  int   pending;
  int   stall_cycles = 0;
  logic [FRAME_W-1:0] held_frames [$];

  pfba_req_if in_ch ();
  pfba_rsp_if out_ch ();

  page_frame_bitmap_allocator_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_alloc_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .rsp_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // granted frames feed later frees
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.ok && out_ch.granted_frame != '0) begin
        held_frames.push_back(out_ch.granted_frame);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input op_t op, input logic [FRAME_W-1:0] frame);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.frame_number <= frame;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random_request();
    int unsigned        pick;
    int unsigned        idx;
    logic [FRAME_W-1:0] frame;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_request(OP_ALLOC, FRAME_W'($urandom));
    end else if (pick < 80 && held_frames.size() > 0) begin
      idx   = $urandom_range(held_frames.size() - 1);
      frame = held_frames[idx];
      held_frames.delete(idx);
      send_request(OP_FREE, frame);
    end else if (pick < 90) begin
      // holes in the reserved area keep the scans short
      send_request(OP_FREE, FRAME_W'($urandom_range(RESERVED_FRAMES - 1)));
    end else begin
      send_request(OP_FREE, FRAME_W'($urandom));
    end
  endtask

  initial begin
    tx_idle_pct        = 6;
    rx_idle_pct        = 84;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_ALLOC;
    in_ch.frame_number <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_FREE, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '1);
    send_request(OP_FREE, 13'd1025);
    send_request(OP_FREE, 13'd1025);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 13'd7);
    send_request(OP_FREE, 13'd1023);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 13'h1555);
    send_request(OP_FREE, 13'h0AAA);
    send_request(OP_FREE, 13'd1024);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 6;
          rx_idle_pct = 84;
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 6;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_ITEMS / 3) send_random_request();
    end

    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 13'd4096);
    send_request(OP_FREE, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
